@@ hdl/pdb_pkg.sv @@
// ----------------------------------------------------------------------------
// pdb_pkg: shared types and constants for point distance and bearing
// Fixed-point formats, the arctangent table and the pipeline control word.
// ----------------------------------------------------------------------------
package pdb_pkg;

	// defaults for the top-level parameters
	localparam int COORD_BITS_DEF     = 24;
	localparam int ROTATION_STEPS_DEF = 16;

	// scaling of the difference vector ahead of the rotations
	localparam int GUARD_BITS = 16;

	// angle accumulator, 16 fraction bits, covers +-(pi/2 + sum of table)
	localparam int ANGLE_W = 20;
	localparam logic signed [ANGLE_W-1:0] HALF_PI = 20'sd102944;

	// result formats
	localparam int DIST_W    = 29;
	localparam int BEARING_W = 16;
	localparam logic signed [BEARING_W:0] BEARING_MAX = 17'sd25736;
	localparam logic signed [BEARING_W:0] BEARING_MIN = -17'sd25736;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// inverse cordic gain, 30 fraction bits
	localparam int GAIN_W = 30;
	localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

	// control word that travels beside the data
	typedef struct packed {
		logic valid;
		logic zero;
	} pdb_ctl_t;

	// round(atan(2^-i) * 65536)
	function automatic logic signed [ANGLE_W-1:0] atan_q16(input int step);
		logic signed [ANGLE_W-1:0] val;
		case (step)
			0:       val = 20'sd51472;
			1:       val = 20'sd30386;
			2:       val = 20'sd16055;
			3:       val = 20'sd8150;
			4:       val = 20'sd4091;
			5:       val = 20'sd2047;
			6:       val = 20'sd1024;
			7:       val = 20'sd512;
			8:       val = 20'sd256;
			9:       val = 20'sd128;
			10:      val = 20'sd64;
			11:      val = 20'sd32;
			12:      val = 20'sd16;
			13:      val = 20'sd8;
			14:      val = 20'sd4;
			15:      val = 20'sd2;
			16:      val = 20'sd1;
			default: val = 20'sd0;
		endcase
		return val;
	endfunction

endpackage

@@ hdl/point_distance_and_bearing.sv @@
// ----------------------------------------------------------------------------
// point_distance_and_bearing: cordic distance and atan2 between two points
// A start word carries a from point and a to point; a done strobe
// later marks the distance and bearing of that pair.
//
// Usage:
//   - a word is taken at each rising edge where start is high and busy is
//     low; busy is held low, so a new pair can enter in every cycle
//   - results pass through registers in order: the difference and
//     quarter-turn fold, one per micro-rotation cell, then the
//     inverse-gain multiply and the bearing rounding
//   - throughput is one pair per cycle, set by the row of rotation cells,
//     each holding one pair in flight
//   - distance is unsigned with 4 fraction bits, bearing is signed radians
//     with 13 fraction bits; equal points give zero for both
//   - done is high for exactly one cycle per word and results must be taken
//     in that cycle; the receiver has no way to hold them
//   - reset clears all valid flags, so no done strobe follows reset until
//     new words are started
// ----------------------------------------------------------------------------
module point_distance_and_bearing #(
	parameter int COORD_BITS     = pdb_pkg::COORD_BITS_DEF,
	parameter int ROTATION_STEPS = pdb_pkg::ROTATION_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [COORD_BITS-1:0]          from_x,
	input  logic signed [COORD_BITS-1:0]          from_y,
	input  logic signed [COORD_BITS-1:0]          to_x,
	input  logic signed [COORD_BITS-1:0]          to_y,
	output logic                                  done,
	output logic [pdb_pkg::DIST_W-1:0]            distance,
	output logic signed [pdb_pkg::BEARING_W-1:0]  bearing
);

	localparam int W = COORD_BITS + pdb_pkg::GUARD_BITS + 3;

	logic signed [W-1:0]                x_c [0:ROTATION_STEPS];
	logic signed [W-1:0]                y_c [0:ROTATION_STEPS];
	logic signed [pdb_pkg::ANGLE_W-1:0] z_c [0:ROTATION_STEPS];
	pdb_pkg::pdb_ctl_t                  ctl_c [0:ROTATION_STEPS];

	// the pipeline never stalls
	assign busy = 1'b0;

	// difference and fold
	pdb_prep #(
		.COORD_BITS (COORD_BITS),
		.W          (W)
	) u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (start & ~busy),
		.from_x (from_x),
		.from_y (from_y),
		.to_x   (to_x),
		.to_y   (to_y),
		.x_s1   (x_c[0]),
		.y_s1   (y_c[0]),
		.z_s1   (z_c[0]),
		.ctl_s1 (ctl_c[0])
	);

	// row of micro-rotation cells
	for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_cell
		pdb_cordic_cell #(
			.W    (W),
			.STEP (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.x_in   (x_c[i]),
			.y_in   (y_c[i]),
			.z_in   (z_c[i]),
			.ctl_in (ctl_c[i]),
			.x_q    (x_c[i+1]),
			.y_q    (y_c[i+1]),
			.z_q    (z_c[i+1]),
			.ctl_q  (ctl_c[i+1])
		);
	end

	// gain correction and bearing rounding
	pdb_post #(
		.W (W)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.x_in     (x_c[ROTATION_STEPS]),
		.z_in     (z_c[ROTATION_STEPS]),
		.ctl_in   (ctl_c[ROTATION_STEPS]),
		.distance (distance),
		.bearing  (bearing),
		.done     (done)
	);

endmodule

@@ hdl/pdb_prep.sv @@
// ----------------------------------------------------------------------------
// pdb_prep: difference vector and quarter-turn fold
// Forms to minus from, folds it into the right half plane and scales it.
// ----------------------------------------------------------------------------
module pdb_prep #(
	parameter int COORD_BITS = pdb_pkg::COORD_BITS_DEF,
	parameter int W          = COORD_BITS + pdb_pkg::GUARD_BITS + 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic signed [COORD_BITS-1:0]         from_x,
	input  logic signed [COORD_BITS-1:0]         from_y,
	input  logic signed [COORD_BITS-1:0]         to_x,
	input  logic signed [COORD_BITS-1:0]         to_y,
	output logic signed [W-1:0]                  x_s1,
	output logic signed [W-1:0]                  y_s1,
	output logic signed [pdb_pkg::ANGLE_W-1:0]   z_s1,
	output pdb_pkg::pdb_ctl_t                    ctl_s1
);

	localparam int D = COORD_BITS + 1;
	localparam int PAD = W - D - pdb_pkg::GUARD_BITS;

	logic signed [D-1:0] dx, dy, fx, fy;
	logic signed [pdb_pkg::ANGLE_W-1:0] fz;

	// difference and fold
	always_comb begin
		dx = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
		dy = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};
		if (dx[D-1]) begin
			if (!dy[D-1]) begin
				fx = dy;
				fy = -dx;
				fz = pdb_pkg::HALF_PI;
			end else begin
				fx = -dy;
				fy = dx;
				fz = -pdb_pkg::HALF_PI;
			end
		end else begin
			fx = dx;
			fy = dy;
			fz = '0;
		end
	end

	// data word register
	always_ff @(posedge clk) begin
		x_s1 <= {{PAD{fx[D-1]}}, fx, {pdb_pkg::GUARD_BITS{1'b0}}};
		y_s1 <= {{PAD{fy[D-1]}}, fy, {pdb_pkg::GUARD_BITS{1'b0}}};
		z_s1 <= fz;
	end

	// control word: valid flag and equal-points flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.zero  <= (dx == '0) && (dy == '0);
		end
	end

endmodule

@@ hdl/pdb_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// pdb_cordic_cell: one vectoring micro-rotation
// Rotates toward the x axis by atan(2^-STEP) and registers the result.
// ----------------------------------------------------------------------------
module pdb_cordic_cell #(
	parameter int W    = 43,
	parameter int STEP = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [W-1:0]                  x_in,
	input  logic signed [W-1:0]                  y_in,
	input  logic signed [pdb_pkg::ANGLE_W-1:0]   z_in,
	input  pdb_pkg::pdb_ctl_t                    ctl_in,
	output logic signed [W-1:0]                  x_q,
	output logic signed [W-1:0]                  y_q,
	output logic signed [pdb_pkg::ANGLE_W-1:0]   z_q,
	output pdb_pkg::pdb_ctl_t                    ctl_q
);

	localparam logic signed [pdb_pkg::ANGLE_W-1:0] ATAN = pdb_pkg::atan_q16(STEP);

	logic signed [W-1:0] sx, sy;

	// arithmetic shifts round toward minus infinity
	assign sx = x_in >>> STEP;
	assign sy = y_in >>> STEP;

	// rotation direction from the sign of y
	always_ff @(posedge clk) begin
		if (!y_in[W-1]) begin
			x_q <= x_in + sy;
			y_q <= y_in - sx;
			z_q <= z_in + ATAN;
		end else begin
			x_q <= x_in - sy;
			y_q <= y_in + sx;
			z_q <= z_in - ATAN;
		end
	end

	// control word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_in;
		end
	end

endmodule

@@ hdl/pdb_post.sv @@
// ----------------------------------------------------------------------------
// pdb_post: gain correction and bearing rounding
// Scales x by the inverse gain in two stages and rounds and clamps the angle.
// ----------------------------------------------------------------------------
module pdb_post #(
	parameter int W = 43
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic signed [W-1:0]                   x_in,
	input  logic signed [pdb_pkg::ANGLE_W-1:0]    z_in,
	input  pdb_pkg::pdb_ctl_t                     ctl_in,
	output logic [pdb_pkg::DIST_W-1:0]            distance,
	output logic signed [pdb_pkg::BEARING_W-1:0]  bearing,
	output logic                                  done
);

	localparam int AW = 32 + pdb_pkg::GAIN_W;
	localparam int LW = AW + 1;
	localparam int SW = AW + 33;
	localparam int HW = SW - 42;
	localparam int BW = pdb_pkg::ANGLE_W - 2;

	logic [63:0] ux;
	logic [31:0] xh, xl;
	logic signed [pdb_pkg::ANGLE_W:0] zr;
	logic signed [BW-1:0] bf;
	logic signed [pdb_pkg::BEARING_W-1:0] bsat;

	logic [AW-1:0] a_s1;
	logic [LW-1:0] lo_s1;
	logic signed [pdb_pkg::BEARING_W-1:0] bearing_s1;
	pdb_pkg::pdb_ctl_t ctl_s1;

	logic [SW-1:0] sum;
	logic [HW-1:0] hi;

	// negative x clamps to zero, split into 32-bit halves
	always_comb begin
		ux = (x_in[W-1] == 1'b0) ? 64'(x_in[W-2:0]) : 64'd0;
		xh = ux[63:32];
		xl = ux[31:0];
	end

	// bearing: round to 13 fraction bits and clamp to +-pi
	always_comb begin
		zr = {z_in[pdb_pkg::ANGLE_W-1], z_in} + (pdb_pkg::ANGLE_W+1)'(4);
		bf = zr[pdb_pkg::ANGLE_W:3];
		if (bf > pdb_pkg::BEARING_MAX) begin
			bsat = pdb_pkg::BEARING_W'(pdb_pkg::BEARING_MAX);
		end else if (bf < pdb_pkg::BEARING_MIN) begin
			bsat = pdb_pkg::BEARING_W'(pdb_pkg::BEARING_MIN);
		end else begin
			bsat = pdb_pkg::BEARING_W'(bf);
		end
	end

	// stage 1: partial products and rounded bearing
	always_ff @(posedge clk) begin
		a_s1       <= AW'(xh) * AW'(pdb_pkg::INV_GAIN_Q30);
		lo_s1      <= LW'(xl) * LW'(pdb_pkg::INV_GAIN_Q30) + (LW'(1) << 41);
		bearing_s1 <= ctl_in.zero ? '0 : bsat;
	end

	// combine partial products and drop 42 fraction bits
	always_comb begin
		sum = {1'b0, a_s1, 32'd0} + SW'(lo_s1);
		hi  = sum[SW-1:42];
	end

	// stage 2: saturate distance, or zero it for equal points
	always_ff @(posedge clk) begin
		if (ctl_s1.zero) begin
			distance <= '0;
		end else if (hi > HW'(pdb_pkg::DIST_MAX)) begin
			distance <= pdb_pkg::DIST_MAX;
		end else begin
			distance <= pdb_pkg::DIST_W'(hi);
		end
		bearing <= bearing_s1;
	end

	// control word and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			done   <= ctl_s1.valid;
		end
	end

endmodule

@@ hdl/pdb_checker.sv @@
// ----------------------------------------------------------------------------
// pdb_checker: port-level checks for point distance and bearing
// Watches start, done and the result words over time.
// ----------------------------------------------------------------------------
module pdb_checker #(
	parameter int LATENCY = pdb_pkg::ROTATION_STEPS_DEF + 3
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic [pdb_pkg::DIST_W-1:0]            distance,
	input logic signed [pdb_pkg::BEARING_W-1:0]  bearing
);

	// every accepted word yields a done after the fixed latency
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted word gave no done strobe");

	// no done without a word accepted at the matching cycle
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("done strobe without an accepted word");

	// bearing stays within +-pi
	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (bearing <= pdb_pkg::BEARING_W'(pdb_pkg::BEARING_MAX)
			&& bearing >= pdb_pkg::BEARING_W'(pdb_pkg::BEARING_MIN)))
		else $error("bearing beyond pi");

	// zero distance only for equal points, which give zero bearing
	a_zero_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(done && distance == '0) |-> (bearing == '0))
		else $error("zero distance with nonzero bearing");

endmodule

bind point_distance_and_bearing pdb_checker #(
	.LATENCY (ROTATION_STEPS + 3)
) u_pdb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.distance (distance),
	.bearing  (bearing)
);
